@@ rtl/core/pwmfd_pkg.sv @@
`timescale 1ns / 1ps

package pwmfd_pkg;

   localparam int COUNT_W    = 16;
   localparam int FREQ_W     = 20;
   localparam int DUTY_W     = 10;
   localparam int TOTAL_W    = 32;
   localparam int IDLE_W     = 17;
   localparam int MODE_W     = 2;
   localparam int PRODUCT_W  = COUNT_W + DUTY_W;

   localparam int COUNT_RATE_DEFAULT = 1000000;

   localparam logic [FREQ_W-1:0]  FREQ_MAX      = '1;
   localparam logic [DUTY_W-1:0]  DUTY_FULL     = 10'd1000;
   localparam logic [IDLE_W-1:0]  IDLE_MAX      = '1;
   localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd100;

   localparam logic [MODE_W-1:0] MODE_RISE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FALL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] period_count;
      logic [COUNT_W-1:0] high_count;
   } req_type;

   typedef struct packed {
      logic [FREQ_W-1:0]  freq_hz;
      logic [DUTY_W-1:0]  duty_permille;
      logic [COUNT_W-1:0] period_us;
      logic [COUNT_W-1:0] high_us;
      logic [TOTAL_W-1:0] capture_total;
      logic               signal_lost;
   } rsp_type;

endpackage

@@ rtl/core/pwmfd_serial_div.sv @@
`timescale 1ns / 1ps

module pwmfd_serial_div #(
   parameter int DIV_W = 27
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIV_W-1:0]             dividend,
   input  logic [pwmfd_pkg::COUNT_W-1:0] divisor,
   output logic                         done,
   output logic [DIV_W-1:0]             quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam int CW    = pwmfd_pkg::COUNT_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [CW-1:0]        dvs_ff, dvs_in;

   logic [CW:0]          trial;
   logic [CW+1:0]        diff;
   logic                 fits;

   // one quotient bit per cycle, dividend shifts out as quotient shifts in
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};
   assign fits  = ~diff[CW+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CW-1:0] : trial[CW-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with empty step count");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> (busy_ff || done_ff))
      else $error("divider dropped a division");
`endif

endmodule

@@ rtl/core/pwm_frequency_duty_meter_unit.sv @@
`timescale 1ns / 1ps

// pwm frequency and duty meter
// req channel: one event beat (rising capture, falling capture, millisecond
//   tick); accepted when req_valid is high and req_stall is low
// rsp channel: exactly one result beat per event, showing the state after it;
//   held in an output register until taken (rsp_valid high, rsp_stall low)
// csr channel: writes timeout_ms; csr_ready is always high, write only idle
// falling capture, tick and zero-period rising capture go from acceptance
//   to ST_RESP, which loads the result once the output register is free
// rising capture with nonzero period runs two serial restoring divisions of
//   DIV_W steps each (frequency, then duty), one quotient bit per cycle,
//   in ST_DIV_F and then ST_DIV_D, before ST_RESP loads the result
// one event is in flight at a time; req_stall is high from acceptance until
//   the result is loaded into the output register, so the next event may be
//   taken while the previous result still waits
// if the receiver stalls, the result holds and the block waits to load
//   the next one
// reset: synchronous, timeout 100, signal lost set, stores zero but prod_ff, rsp_data_ff

module pwm_frequency_duty_meter_unit #(
   parameter int COUNT_RATE_HZ = pwmfd_pkg::COUNT_RATE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pwmfd_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pwmfd_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pwmfd_pkg::COUNT_W-1:0] csr_data
);

   localparam int RATE_W = $clog2(COUNT_RATE_HZ + 1);
   localparam int DIV_W  = (RATE_W > pwmfd_pkg::PRODUCT_W) ? RATE_W : pwmfd_pkg::PRODUCT_W;
   localparam int CW     = pwmfd_pkg::COUNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_F,
      ST_DIV_D,
      ST_RESP
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 timeout_ff, timeout_in;
   logic [CW-1:0]                 period_ff, period_in;
   logic [CW-1:0]                 high_ff, high_in;
   logic [pwmfd_pkg::FREQ_W-1:0]  freq_ff, freq_in;
   logic [pwmfd_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic [pwmfd_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [pwmfd_pkg::IDLE_W-1:0]  idle_ff, idle_in;
   logic                          lost_ff, lost_in;
   logic [DIV_W-1:0]              prod_ff, prod_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pwmfd_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                              req_accept;
   logic                              out_free;
   logic                              div_start;
   logic [DIV_W-1:0]                  div_dividend;
   logic [CW-1:0]                     div_divisor;
   logic                              div_done;
   logic [DIV_W-1:0]                  div_quotient;
   logic [pwmfd_pkg::PRODUCT_W-1:0]   product;
   logic [pwmfd_pkg::IDLE_W-1:0]      idle_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   assign product = {{pwmfd_pkg::DUTY_W{1'b0}}, req_data.high_count}
                  * {{CW{1'b0}}, pwmfd_pkg::DUTY_FULL};

   assign idle_next = (idle_ff < pwmfd_pkg::IDLE_MAX)
                    ? idle_ff + pwmfd_pkg::IDLE_W'(1) : idle_ff;

   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_W'(COUNT_RATE_HZ);
      div_divisor  = period_ff;
      if (state_ff == ST_IDLE) begin
         div_divisor = req_data.period_count;
         div_start   = req_accept && (req_data.mode == pwmfd_pkg::MODE_RISE)
                     && (req_data.period_count != '0);
      end else if (state_ff == ST_DIV_F) begin
         div_dividend = prod_ff;
         div_start    = div_done;
      end
   end

   pwmfd_serial_div #(
      .DIV_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      timeout_in   = timeout_ff;
      period_in    = period_ff;
      high_in      = high_ff;
      freq_in      = freq_ff;
      duty_in      = duty_ff;
      total_in     = total_ff;
      idle_in      = idle_ff;
      lost_in      = lost_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         timeout_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_RESP;
               case (req_data.mode)
                  pwmfd_pkg::MODE_RISE: begin
                     period_in = req_data.period_count;
                     high_in   = req_data.high_count;
                     idle_in   = '0;
                     lost_in   = 1'b0;
                     total_in  = total_ff + pwmfd_pkg::TOTAL_W'(1);
                     prod_in   = DIV_W'(product);
                     if (req_data.period_count != '0) begin
                        state_in = ST_DIV_F;
                     end
                  end
                  pwmfd_pkg::MODE_FALL: begin
                     high_in = req_data.high_count;
                     idle_in = '0;
                  end
                  pwmfd_pkg::MODE_TICK: begin
                     idle_in = idle_next;
                     if (idle_next > {1'b0, timeout_ff}) begin
                        lost_in = 1'b1;
                        freq_in = '0;
                        duty_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV_F: begin
            if (div_done) begin
               freq_in  = (div_quotient > DIV_W'(pwmfd_pkg::FREQ_MAX))
                        ? pwmfd_pkg::FREQ_MAX : div_quotient[pwmfd_pkg::FREQ_W-1:0];
               state_in = ST_DIV_D;
            end
         end
         ST_DIV_D: begin
            if (div_done) begin
               duty_in  = (div_quotient > DIV_W'(pwmfd_pkg::DUTY_FULL))
                        ? pwmfd_pkg::DUTY_FULL : div_quotient[pwmfd_pkg::DUTY_W-1:0];
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.freq_hz       = freq_ff;
               rsp_data_in.duty_permille = duty_ff;
               rsp_data_in.period_us     = period_ff;
               rsp_data_in.high_us       = high_ff;
               rsp_data_in.capture_total = total_ff;
               rsp_data_in.signal_lost   = lost_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= pwmfd_pkg::TIMEOUT_RESET;
         period_ff    <= '0;
         high_ff      <= '0;
         freq_ff      <= '0;
         duty_ff      <= '0;
         total_ff     <= '0;
         idle_ff      <= '0;
         lost_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         period_ff    <= period_in;
         high_ff      <= high_in;
         freq_ff      <= freq_in;
         duty_ff      <= duty_in;
         total_ff     <= total_in;
         idle_ff      <= idle_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_lost_zeroes: assert property (@(posedge clock) disable iff (reset)
      lost_ff |-> (freq_ff == '0) && (duty_ff == '0))
      else $error("lost signal with nonzero frequency or duty");
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_ff <= pwmfd_pkg::DUTY_FULL)
      else $error("duty above full scale");
   a_rise_clears_lost: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.mode == pwmfd_pkg::MODE_RISE) |=> !lost_ff)
      else $error("rising capture left signal lost");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_F) || (state_ff == ST_DIV_D))
      else $error("division finished outside a division state");
`endif

endmodule

@@ test/pwm_frequency_duty_meter_unit_tb.sv @@
`timescale 1ns / 1ps

module pwm_frequency_duty_meter_unit_tb;

   typedef logic [pwmfd_pkg::COUNT_W-1:0] count_type;
   typedef logic [pwmfd_pkg::MODE_W-1:0]  mode_type;

   localparam int unsigned RATE_HZ = pwmfd_pkg::COUNT_RATE_DEFAULT;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam mode_type MODE_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pwmfd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pwmfd_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   count_type csr_data = '0;

   pwm_frequency_duty_meter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // meter state as the block should hold it
   count_type                        timeout_q;
   count_type                        period_q;
   count_type                        high_q;
   logic [pwmfd_pkg::FREQ_W-1:0]     freq_q;
   logic [pwmfd_pkg::DUTY_W-1:0]     duty_q;
   logic [pwmfd_pkg::TOTAL_W-1:0]    captures_q;
   logic [pwmfd_pkg::IDLE_W-1:0]     idle_q;
   logic                             lost_q;

   pwmfd_pkg::rsp_type readings_due[$];
   int mismatches = 0;
   int events_sent = 0;
   int readings_seen = 0;
   int rises_sent = 0;
   int ticks_sent = 0;
   int losses_seen = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void meter_reset();
      timeout_q = pwmfd_pkg::TIMEOUT_RESET;
      period_q = '0;
      high_q = '0;
      freq_q = '0;
      duty_q = '0;
      captures_q = '0;
      idle_q = '0;
      lost_q = 1'b1;
   endfunction

   function automatic pwmfd_pkg::rsp_type meter_apply(pwmfd_pkg::req_type ev);
      int unsigned freq_calc;
      int unsigned duty_calc;
      pwmfd_pkg::rsp_type r;
      case (ev.mode)
         pwmfd_pkg::MODE_RISE: begin
            period_q = ev.period_count;
            high_q = ev.high_count;
            if (ev.period_count != '0) begin
               freq_calc = RATE_HZ / int'(ev.period_count);
               duty_calc = (int'(ev.high_count) * 1000) / int'(ev.period_count);
               freq_q = (freq_calc > pwmfd_pkg::FREQ_MAX) ? pwmfd_pkg::FREQ_MAX
                                                          : freq_calc[pwmfd_pkg::FREQ_W-1:0];
               duty_q = (duty_calc > pwmfd_pkg::DUTY_FULL) ? pwmfd_pkg::DUTY_FULL
                                                           : duty_calc[pwmfd_pkg::DUTY_W-1:0];
            end
            idle_q = '0;
            lost_q = 1'b0;
            captures_q = captures_q + 1'b1;
         end
         pwmfd_pkg::MODE_FALL: begin
            high_q = ev.high_count;
            idle_q = '0;
         end
         pwmfd_pkg::MODE_TICK: begin
            if (idle_q != pwmfd_pkg::IDLE_MAX)
               idle_q = idle_q + 1'b1;
            if (idle_q > {1'b0, timeout_q}) begin
               if (!lost_q)
                  losses_seen++;
               lost_q = 1'b1;
               freq_q = '0;
               duty_q = '0;
            end
         end
         default: ;
      endcase
      r.freq_hz = freq_q;
      r.duty_permille = duty_q;
      r.period_us = period_q;
      r.high_us = high_q;
      r.capture_total = captures_q;
      r.signal_lost = lost_q;
      return r;
   endfunction

   function automatic int draw_wait();
      return quiet ? 0 : $urandom_range(0, 18);
   endfunction

   // valid stays high after a beat so that a back-to-back beat needs no toggle
   task automatic send_event(input mode_type mode,
                             input count_type period,
                             input count_type high);
      pwmfd_pkg::req_type ev;
      int gap;
      ev.mode = mode;
      ev.period_count = period;
      ev.high_count = high;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (req_stall);
      readings_due.push_back(meter_apply(ev));
      events_sent++;
      if (mode == pwmfd_pkg::MODE_RISE)
         rises_sent++;
      if (mode == pwmfd_pkg::MODE_TICK)
         ticks_sent++;
   endtask

   task automatic drain_readings();
      req_valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(input count_type value);
      drain_readings();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      timeout_q = value;
      csr_valid <= 1'b0;
   endtask

   task automatic send_pulse_train(output int count);
      int unsigned pick;
      int unsigned base;
      int unsigned period;
      int unsigned high;
      int unsigned ticks;
      int unsigned n;
      count = 0;
      quiet = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // noise: any mode, any fields, zero period included
         send_event(mode_type'($urandom_range(0, 3)),
                    (pick < 4) ? 16'd0 : count_type'($urandom_range(0, 65535)),
                    count_type'($urandom_range(0, 65535)));
         count = 1;
      end else begin
         base = (pick < 45) ? $urandom_range(1, 64) : $urandom_range(1, 65535);
         n = $urandom_range(1, 6);
         repeat (n) begin
            period = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : base;
            high = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, period);
            send_event(pwmfd_pkg::MODE_RISE, count_type'(period), count_type'(high));
            count++;
            if ($urandom_range(0, 1)) begin
               send_event(pwmfd_pkg::MODE_FALL, count_type'($urandom_range(0, 65535)),
                          count_type'($urandom_range(0, period)));
               count++;
            end
            ticks = $urandom_range(0, (timeout_q < 10) ? timeout_q + 2 : 3);
            repeat (ticks) begin
               send_event(pwmfd_pkg::MODE_TICK, count_type'($urandom_range(0, 65535)),
                          count_type'($urandom_range(0, 65535)));
               count++;
            end
         end
      end
   endtask

   task automatic test_idle_and_unused();
      send_event(MODE_SPARE, 16'hFFFF, 16'hFFFF);
      send_event(pwmfd_pkg::MODE_TICK, count_type'($urandom_range(0, 65535)),
                 count_type'($urandom_range(0, 65535)));
      send_event(pwmfd_pkg::MODE_FALL, 16'h0000, 16'hFFFF);
      send_event(pwmfd_pkg::MODE_TICK, 16'h0000, 16'h0000);
   endtask

   task automatic test_capture_extremes();
      send_event(pwmfd_pkg::MODE_RISE, 16'd1, 16'd0);
      send_event(pwmfd_pkg::MODE_RISE, 16'hFFFF, 16'hFFFF);
      send_event(pwmfd_pkg::MODE_RISE, 16'hFFFF, 16'd0);
      send_event(pwmfd_pkg::MODE_RISE, 16'd10, 16'hFFFF);
      send_event(pwmfd_pkg::MODE_RISE, 16'd3, 16'd2);
      send_event(pwmfd_pkg::MODE_RISE, 16'd0, 16'h1234);
      send_event(pwmfd_pkg::MODE_FALL, 16'hFFFF, 16'd7);
      send_event(MODE_SPARE, 16'd0, 16'd0);
   endtask

   task automatic test_timeout_limits();
      write_timeout(16'd0);
      send_event(pwmfd_pkg::MODE_RISE, 16'd1000, 16'd250);
      send_event(pwmfd_pkg::MODE_TICK, 16'd0, 16'd0);
      send_event(pwmfd_pkg::MODE_FALL, 16'd0, 16'd500);
      send_event(pwmfd_pkg::MODE_TICK, 16'd0, 16'd0);
      send_event(pwmfd_pkg::MODE_RISE, 16'd500, 16'd499);
      write_timeout(16'd3);
      send_event(pwmfd_pkg::MODE_RISE, 16'd2000, 16'd1000);
      repeat (5) send_event(pwmfd_pkg::MODE_TICK, 16'd0, 16'd0);
      send_event(pwmfd_pkg::MODE_FALL, 16'd0, 16'd1500);
      send_event(pwmfd_pkg::MODE_TICK, 16'd0, 16'd0);
      write_timeout(16'hFFFF);
      send_event(pwmfd_pkg::MODE_RISE, 16'd40000, 16'd1);
      repeat (3) send_event(pwmfd_pkg::MODE_TICK, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_random_traffic();
      count_type limits [6];
      int sent;
      int chunk;
      bit paused;
      limits = '{16'd100, 16'd0, 16'd1, 16'd7, 16'hFFFF, 16'd0};
      limits[5] = count_type'($urandom_range(0, 65535));
      paused = 1'b0;
      for (int p = 0; p < 6; p++) begin
         write_timeout(limits[p]);
         sent = 0;
         while (sent < 225) begin
            send_pulse_train(chunk);
            sent += chunk;
            if (!paused && p == 2 && sent > 100) begin
               drain_readings();
               paused = 1'b1;
            end
         end
      end
      quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      pwmfd_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            readings_seen++;
            if (readings_due.size() == 0) begin
               $error("result beat with no event outstanding");
               mismatches++;
            end else begin
               want = readings_due.pop_front();
               if (rsp_data.freq_hz !== want.freq_hz) begin
                  $error("freq_hz expected %0d got %0d", want.freq_hz, rsp_data.freq_hz);
                  mismatches++;
               end
               if (rsp_data.duty_permille !== want.duty_permille) begin
                  $error("duty_permille expected %0d got %0d",
                         want.duty_permille, rsp_data.duty_permille);
                  mismatches++;
               end
               if (rsp_data.period_us !== want.period_us) begin
                  $error("period_us expected %0d got %0d", want.period_us, rsp_data.period_us);
                  mismatches++;
               end
               if (rsp_data.high_us !== want.high_us) begin
                  $error("high_us expected %0d got %0d", want.high_us, rsp_data.high_us);
                  mismatches++;
               end
               if (rsp_data.capture_total !== want.capture_total) begin
                  $error("capture_total expected %0d got %0d",
                         want.capture_total, rsp_data.capture_total);
                  mismatches++;
               end
               if (rsp_data.signal_lost !== want.signal_lost) begin
                  $error("signal_lost expected %0d got %0d",
                         want.signal_lost, rsp_data.signal_lost);
                  mismatches++;
               end
            end
            stall_left = draw_wait();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no beat accepted for %0d cycles", idle_cycles);
         $display("FAIL pwm_frequency_duty_meter_unit");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      meter_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_idle_and_unused();
      test_capture_extremes();
      test_timeout_limits();
      test_random_traffic();
      drain_readings();
      repeat (100) @(posedge clock);
      if (readings_due.size() != 0) begin
         $error("%0d results never arrived", readings_due.size());
         mismatches++;
      end
      $display("covered %0d events (%0d rising captures, %0d ticks) and %0d results",
               events_sent, rises_sent, ticks_sent, readings_seen);
      $display("timeouts 0 to 65535 exercised, %0d signal losses, %0d mismatches",
               losses_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS pwm_frequency_duty_meter_unit");
      end else begin
         $display("FAIL pwm_frequency_duty_meter_unit");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/pwmfd_pkg.sv
rtl/core/pwmfd_serial_div.sv
rtl/core/pwm_frequency_duty_meter_unit.sv
test/pwm_frequency_duty_meter_unit_tb.sv
